// ===== rtl/dat_pkg.sv =====
package dat_pkg;

    // Default table size, handed to the top level as its parameter default
    localparam int TABLE_DEPTH_DEF = 64;

    // Fixed field widths of the item and result beats
    localparam int ADDR_W  = 48;
    localparam int RSSI_W  = 8;
    localparam int TIME_W  = 32;
    localparam int PKT_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    // Action codes
    localparam logic [1:0] ACT_REPORT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_READ_ERR = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]               action;
        logic [ADDR_W-1:0]        raw_address;
        logic signed [RSSI_W-1:0] signal_strength;
        logic [TIME_W-1:0]        timestamp_ms;
        logic [SLOT_W-1:0]        read_index;
    } t_item;

    typedef struct packed {
        logic [2:0]               status;
        logic [SLOT_W-1:0]        slot;
        logic [COUNT_W-1:0]       entry_count;
        logic [ADDR_W-1:0]        entry_address;
        logic signed [RSSI_W-1:0] entry_strength;
        logic [TIME_W-1:0]        entry_last_seen;
        logic [PKT_W-1:0]         entry_packets;
    } t_result;

    // One table entry as held in the memory
    typedef struct packed {
        logic [ADDR_W-1:0]        address;
        logic signed [RSSI_W-1:0] strength;
        logic [TIME_W-1:0]        last_seen;
        logic [PKT_W-1:0]         packets;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_READ
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input beat
        logic scan_init;   // rewind the scan pointer
        logic scan_step;   // issue next scan read, compare previous
        logic upd;         // write back hit entry, emit updated
        logic ins;         // append new entry, emit inserted
        logic drop;        // emit dropped
        logic rd_req;      // read entry at index
        logic rd_emit;     // emit read data
        logic rd_err;      // emit range error
        logic clear;       // empty the table, emit cleared
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       idx_ok;
        logic       hit;
        logic       scan_done;
        logic       full;
    } t_dp_stat;

    // Reverse byte order of a received address into display order
    function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] raw);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int k = 0; k < ADDR_W / 8; k++) begin
            r[8*(ADDR_W/8-1-k) +: 8] = raw[8*k +: 8];
        end
        return r;
    endfunction

endpackage

// ===== rtl/dat_ctrl.sv =====
module dat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dat_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output dat_pkg::t_dp_cmd  o_cmd
);

    dat_pkg::t_state r_state;
    dat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dat_pkg::S_IDLE: begin
                if (i_start) n_state = dat_pkg::S_DECODE;
            end
            dat_pkg::S_DECODE: begin
                case (i_stat.action)
                    dat_pkg::ACT_REPORT: n_state = dat_pkg::S_SEARCH;
                    dat_pkg::ACT_READ: begin
                        n_state = i_stat.idx_ok ? dat_pkg::S_READ : dat_pkg::S_IDLE;
                    end
                    default: n_state = dat_pkg::S_IDLE;
                endcase
            end
            dat_pkg::S_SEARCH: begin
                if (i_stat.hit || i_stat.scan_done) n_state = dat_pkg::S_IDLE;
            end
            dat_pkg::S_READ: n_state = dat_pkg::S_IDLE;
            default: n_state = dat_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != dat_pkg::S_IDLE);
        case (r_state)
            dat_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            dat_pkg::S_DECODE: begin
                case (i_stat.action)
                    dat_pkg::ACT_REPORT: o_cmd.scan_init = 1'b1;
                    dat_pkg::ACT_READ: begin
                        o_cmd.rd_req = i_stat.idx_ok;
                        o_cmd.rd_err = !i_stat.idx_ok;
                    end
                    dat_pkg::ACT_CLEAR: o_cmd.clear = 1'b1;
                    default: o_cmd = '0;
                endcase
            end
            dat_pkg::S_SEARCH: begin
                if (i_stat.hit) begin
                    o_cmd.upd = 1'b1;
                end else if (i_stat.scan_done) begin
                    o_cmd.ins  = !i_stat.full;
                    o_cmd.drop = i_stat.full;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            dat_pkg::S_READ: o_cmd.rd_emit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/dat_dpath.sv =====
module dat_dpath #(
    parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dat_pkg::t_item    i_item,
    input  dat_pkg::t_dp_cmd  i_cmd,
    output dat_pkg::t_dp_stat o_stat,
    output dat_pkg::t_result  o_result,
    output logic              o_valid
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    dat_pkg::t_entry mem [TABLE_DEPTH];

    dat_pkg::t_item   r_item;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_ptr;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_slot;
    dat_pkg::t_entry  r_rdata;
    dat_pkg::t_result r_result;
    logic             r_valid;

    logic [dat_pkg::ADDR_W-1:0] w_addr;
    logic [31:0]                w_idx32;
    logic [31:0]                w_cnt32;
    logic [31:0]                w_cmp32;
    logic [IW-1:0]              w_idx;
    logic [dat_pkg::PKT_W-1:0]  w_pkts;
    logic                       w_issue;
    logic                       w_wr_en;
    logic [IW-1:0]              w_wr_addr;
    dat_pkg::t_entry            w_wr_data;
    logic                       w_rd_en;
    logic [IW-1:0]              w_rd_addr;
    logic                       w_emit;
    dat_pkg::t_result           n_result;

    assign w_addr  = dat_pkg::swap_bytes(r_item.raw_address);
    assign w_idx32 = 32'(r_item.read_index);
    assign w_cnt32 = 32'(r_count);
    assign w_cmp32 = 32'(r_cmp_slot);
    assign w_idx   = w_idx32[IW-1:0];
    assign w_pkts  = (r_rdata.packets == '1) ? r_rdata.packets : r_rdata.packets + 1'b1;
    assign w_issue = i_cmd.scan_step && (r_ptr < r_count);

    assign o_stat.action    = r_item.action;
    assign o_stat.idx_ok    = (w_idx32 < w_cnt32);
    assign o_stat.hit       = r_cmp_vld && (r_rdata.address == w_addr);
    assign o_stat.scan_done = !r_cmp_vld && (r_ptr >= r_count);
    assign o_stat.full      = (r_count == CW'(TABLE_DEPTH));

    // Memory write port: hit write-back or append
    assign w_wr_en   = i_cmd.upd || i_cmd.ins;
    assign w_wr_addr = i_cmd.upd ? r_cmp_slot : r_count[IW-1:0];
    assign w_wr_data.address   = w_addr;
    assign w_wr_data.strength  = r_item.signal_strength;
    assign w_wr_data.last_seen = r_item.timestamp_ms;
    assign w_wr_data.packets   = i_cmd.upd ? w_pkts : dat_pkg::PKT_W'(1);

    assign w_rd_en   = w_issue || i_cmd.rd_req;
    assign w_rd_addr = i_cmd.rd_req ? w_idx : r_ptr[IW-1:0];

    assign w_emit = i_cmd.upd || i_cmd.ins || i_cmd.drop || i_cmd.rd_emit
                 || i_cmd.rd_err || i_cmd.clear;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rdata <= mem[w_rd_addr];
    end

    always_comb begin
        n_result             = '0;
        n_result.entry_count = w_cnt32[dat_pkg::COUNT_W-1:0];
        if (i_cmd.upd) begin
            n_result.status          = dat_pkg::ST_UPDATED;
            n_result.slot            = w_cmp32[dat_pkg::SLOT_W-1:0];
            n_result.entry_address   = w_addr;
            n_result.entry_strength  = r_item.signal_strength;
            n_result.entry_last_seen = r_item.timestamp_ms;
            n_result.entry_packets   = w_pkts;
        end else if (i_cmd.ins) begin
            n_result.status          = dat_pkg::ST_INSERTED;
            n_result.slot            = w_cnt32[dat_pkg::SLOT_W-1:0];
            n_result.entry_count     = 7'(w_cnt32 + 32'd1);
            n_result.entry_address   = w_addr;
            n_result.entry_strength  = r_item.signal_strength;
            n_result.entry_last_seen = r_item.timestamp_ms;
            n_result.entry_packets   = dat_pkg::PKT_W'(1);
        end else if (i_cmd.drop) begin
            n_result.status = dat_pkg::ST_DROPPED;
        end else if (i_cmd.rd_emit) begin
            n_result.status          = dat_pkg::ST_READ_OK;
            n_result.slot            = r_item.read_index;
            n_result.entry_address   = r_rdata.address;
            n_result.entry_strength  = r_rdata.strength;
            n_result.entry_last_seen = r_rdata.last_seen;
            n_result.entry_packets   = r_rdata.packets;
        end else if (i_cmd.rd_err) begin
            n_result.status = dat_pkg::ST_READ_ERR;
        end else if (i_cmd.clear) begin
            n_result.status      = dat_pkg::ST_CLEARED;
            n_result.entry_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (w_emit) r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= w_emit;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.ins) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= w_issue;
                if (w_issue) r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) r_cmp_slot <= r_ptr[IW-1:0];
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule

// ===== rtl/device_address_tracking_table.sv =====
// Device address tracking table.
//
// Command channel: drive i_item and raise start; the beat is taken at the
// rising edge where start is high and busy is low. busy stays high until
// the item is finished, and the next beat may follow in the cycle busy drops.
// Result channel: one result beat per item (none for the unused action code)
// on o_result, marked by o_valid for exactly one cycle. There is no
// back-pressure: sample o_result whenever o_valid is high.
//
// o_valid is registered behind the state that emits the result. Clear and
// an out-of-range read emit from the decode state; a read emits from the
// read state once the entry is fetched; a report emits when the scan hits
// (write back) or runs past the filled entries (insert, or drop when full),
// so a hit waits longer the higher its slot. The scan does one memory read
// per cycle over the filled slots, from slot 0 upward, with the compare in
// the cycle after the read. One item is worked on at a time.
//
// Reset clears the fill count and the controller; the entry memory keeps
// its contents, which are only reachable below the fill count.
module device_address_tracking_table #(
    parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dat_pkg::t_item   i_item,
    output dat_pkg::t_result o_result,
    output logic             o_valid
);

    dat_pkg::t_dp_cmd  w_cmd;
    dat_pkg::t_dp_stat w_stat;

    // Sequence each item: decode, then scan and write back, append or drop, or read or clear, and emit
    dat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Hold the entry memory, fill count, scan pointer and result register
    dat_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

// ===== rtl/dat_chk.sv =====
module dat_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dat_pkg::t_result o_result,
    input logic             o_valid
);

    // Reset leaves the block idle with no beat on the result side
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

    // An accepted item always raises busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // One item gives one beat, so beats never come back to back
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // A clear empties the table
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == dat_pkg::ST_CLEARED) |-> (o_result.entry_count == '0))
        else $error("clear left a non-zero count");

    // Results without an entry carry zero slot, address and packet fields
    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == dat_pkg::ST_DROPPED
                  || o_result.status == dat_pkg::ST_READ_ERR
                  || o_result.status == dat_pkg::ST_CLEARED))
        |-> (o_result.slot == '0 && o_result.entry_packets == '0
          && o_result.entry_address == '0))
        else $error("entry fields not cleared on an entry-less result");

endmodule

bind device_address_tracking_table dat_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_valid  (o_valid)
);

// ===== tb/sv/tb.sv =====
module tb;

    import dat_pkg::*;

    // Table size used for this run; the predictor mirrors the same depth
    localparam int DEPTH         = TABLE_DEPTH_DEF;
    // Action code that the block ignores: no result, no state change
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Random beats after the directed part, spread over the idling phases
    localparam int RANDOM_ITEMS  = 1530;
    localparam int PHASES        = 4;
    // Addresses that come back again and again, so that hits and a full
    // table both happen; more of them than the table can hold
    localparam int POOL_SIZE     = 72;
    // Watchdog limit, in clock cycles
    localparam int LIMIT_CYCLES  = 1_000_000;

    // One command beat waiting to be offered, with the sender's idling for
    // it and whether the sender first holds off until the table has answered
    // everything in flight
    typedef struct packed {
        t_item      item;
        logic [6:0] idle_pct;
        logic       drain;
    } t_pending;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    t_result o_result;
    logic    o_valid;

    t_pending item_backlog [$];
    t_result  due_results  [$];
    int       mismatches = 0;

    // Mirror of the device table: entries below seen_fill are live
    logic [ADDR_W-1:0]        seen_addr [DEPTH];
    logic signed [RSSI_W-1:0] seen_rssi [DEPTH];
    logic [TIME_W-1:0]        seen_time [DEPTH];
    logic [PKT_W-1:0]         seen_pkts [DEPTH];
    int                       seen_fill = 0;

    device_address_tracking_table #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_result(o_result),
        .o_valid (o_valid)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hold reset from the start, then release it for good
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Work out what the table answers to one command beat and advance the
    // mirror. Returns 0 for the ignored action, which answers nothing.
    function automatic bit track_device(input t_item cmd, output t_result res);
        logic [ADDR_W-1:0] key;
        int                found;
        int                shown;
        res   = '0;
        found = -1;
        shown = -1;
        case (cmd.action)
            ACT_REPORT: begin
                // Received order is least significant byte first: flip it
                key = {cmd.raw_address[7:0],   cmd.raw_address[15:8],
                       cmd.raw_address[23:16], cmd.raw_address[31:24],
                       cmd.raw_address[39:32], cmd.raw_address[47:40]};
                for (int s = 0; s < seen_fill; s++) begin
                    if (found < 0 && seen_addr[s] == key) found = s;
                end
                if (found >= 0) begin
                    seen_rssi[found] = cmd.signal_strength;
                    seen_time[found] = cmd.timestamp_ms;
                    // Packet count sticks at its top value
                    if (seen_pkts[found] != '1) seen_pkts[found] = seen_pkts[found] + 1'b1;
                    res.status = ST_UPDATED;
                    shown      = found;
                end else if (seen_fill < DEPTH) begin
                    seen_addr[seen_fill] = key;
                    seen_rssi[seen_fill] = cmd.signal_strength;
                    seen_time[seen_fill] = cmd.timestamp_ms;
                    seen_pkts[seen_fill] = PKT_W'(1);
                    res.status = ST_INSERTED;
                    shown      = seen_fill;
                    seen_fill++;
                end else begin
                    res.status = ST_DROPPED;
                end
            end
            ACT_READ: begin
                if (int'(cmd.read_index) < seen_fill) begin
                    res.status = ST_READ_OK;
                    shown      = int'(cmd.read_index);
                end else begin
                    res.status = ST_READ_ERR;
                end
            end
            ACT_CLEAR: begin
                // Old entries stay in the memory but drop out of reach
                seen_fill  = 0;
                res.status = ST_CLEARED;
            end
            default: return 1'b0;
        endcase
        res.entry_count = seen_fill[COUNT_W-1:0];
        if (shown >= 0) begin
            res.slot            = shown[SLOT_W-1:0];
            res.entry_address   = seen_addr[shown];
            res.entry_strength  = seen_rssi[shown];
            res.entry_last_seen = seen_time[shown];
            res.entry_packets   = seen_pkts[shown];
        end
        return 1'b1;
    endfunction

    task automatic queue_beat(input logic [1:0] act, input logic [ADDR_W-1:0] raw,
                              input logic [RSSI_W-1:0] rssi, input logic [TIME_W-1:0] ts,
                              input logic [SLOT_W-1:0] idx, input int unsigned pct,
                              input bit drain);
        t_pending p;
        p.item.action          = act;
        p.item.raw_address     = raw;
        p.item.signal_strength = rssi;
        p.item.timestamp_ms    = ts;
        p.item.read_index      = idx;
        p.idle_pct             = pct[6:0];
        p.drain                = drain;
        item_backlog.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: note the beat taken at this edge, predict its answer, then
    // offer the next beat or idle. A beat on offer is held until taken.
    always @(posedge i_clk) begin : drive_beats
        logic     taken;
        logic     nxt_start;
        t_result  outcome;
        t_pending head;
        taken     = start && !busy;
        nxt_start = start && !taken;
        if (taken && track_device(i_item, outcome)) due_results.push_back(outcome);
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!nxt_start && item_backlog.size() != 0) begin
            head = item_backlog[0];
            // Pause until every answer in flight has come back, where asked
            if (!(head.drain && due_results.size() != 0) &&
                $urandom_range(99) >= head.idle_pct) begin
                i_item <= head.item;
                void'(item_backlog.pop_front());
                nxt_start = 1'b1;
            end
        end
        start <= nxt_start;
    end

    // Monitor: every strobed result is matched against the oldest answer due
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing due: %p", o_result);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_result.status));
                check_field("slot", 64'(want.slot), 64'(o_result.slot));
                check_field("entry_count", 64'(want.entry_count),
                            64'(o_result.entry_count));
                check_field("entry_address", 64'(want.entry_address),
                            64'(o_result.entry_address));
                check_field("entry_strength", 64'(want.entry_strength[RSSI_W-1:0]),
                            64'(o_result.entry_strength[RSSI_W-1:0]));
                check_field("entry_last_seen", 64'(want.entry_last_seen),
                            64'(o_result.entry_last_seen));
                check_field("entry_packets", 64'(want.entry_packets),
                            64'(o_result.entry_packets));
            end
        end
    end

    initial begin : stimulus
        logic [ADDR_W-1:0] pool [POOL_SIZE];
        logic [ADDR_W-1:0] raw;
        logic [31:0]       bits;
        int unsigned       phase_pct [PHASES];
        int unsigned       roll;
        logic [1:0]        act;
        int                made;

        // Directed opening: empty table, extreme fields, byte order, hits,
        // reads in and out of range, the ignored action, clear and refill
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_CLEAR,  '0, 8'h00, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, '0, 8'h80, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, '1, 8'h7F, '1, '1, 0, 1'b0);
        queue_beat(ACT_REPORT, '0, 8'h00, 32'h1, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, 48'h6655_4433_2211, 8'hC4, 32'h1234_5678, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, '1, 8'hFF, 32'h8000_0000, 6'd0, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd1, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd2, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd3, 0, 1'b0);
        queue_beat(ACT_READ,   '1, 8'h7F, '1, 6'd63, 0, 1'b0);
        queue_beat(ACT_UNUSED, '1, 8'hFF, '1, '1, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd2, 0, 1'b0);
        queue_beat(ACT_CLEAR,  '1, 8'hFF, '1, '1, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, 48'h6655_4433_2211, 8'h01, 32'hFFFF_FFFE, 6'd0, 0, 1'b0);
        queue_beat(ACT_REPORT, '0, 8'h80, 32'h0, 6'd0, 0, 1'b0);
        queue_beat(ACT_READ,   '0, 8'h00, 32'h0, 6'd1, 0, 1'b0);

        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k][47:32] = 16'($urandom_range(16'hFFFF));
            pool[k][31:0]  = $urandom();
        end

        // Sender idling per phase: none, heavy, none again, light. The
        // receiver cannot stall, so only the sender's gaps vary.
        phase_pct[0] = 0;
        phase_pct[1] = 85;
        phase_pct[2] = 0;
        phase_pct[3] = 25;

        // Random part: mostly reports from the recurring pool, so the table
        // fills, hits and overflows; reads over the whole index range; rare
        // clears; a sprinkle of ignored beats that do not count. Each phase
        // opens with the sender holding off until all answers are in.
        for (int ph = 0; ph < PHASES; ph++) begin
            made = 0;
            while (made < RANDOM_ITEMS / PHASES) begin
                roll = $urandom_range(999);
                if (roll < 20)       act = ACT_UNUSED;
                else if (roll < 25)  act = ACT_CLEAR;
                else if (roll < 275) act = ACT_READ;
                else                 act = ACT_REPORT;
                raw[47:32] = 16'($urandom_range(16'hFFFF));
                raw[31:0]  = $urandom();
                if (act == ACT_REPORT && $urandom_range(99) < 85)
                    raw = pool[$urandom_range(POOL_SIZE - 1)];
                bits = $urandom();
                queue_beat(act, raw, bits[7:0], $urandom(), bits[13:8],
                           phase_pct[ph], made == 0);
                if (act != ACT_UNUSED) made++;
            end
        end

        // Drain: every beat taken, every answer in, then a scan's worth of
        // quiet cycles to catch any stray result
        while (item_backlog.size() != 0 || start) @(negedge i_clk);
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DEPTH + 8) @(negedge i_clk);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a lost result ends the run here
    initial begin : watchdog
        #(LIMIT_CYCLES * 8);
        $display("TEST FAILED");
        $finish;
    end

endmodule
